// ----- hdl/capability_access_checker_macros.svh -----
// Assertion macros shared by the capability access checker's checker module.
`ifndef CAPABILITY_ACCESS_CHECKER_MACROS_SVH
`define CAPABILITY_ACCESS_CHECKER_MACROS_SVH

// Same-cycle implication, clocked on the rising edge, disabled in reset.
`define CAC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on the rising edge, disabled in reset.
`define CAC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cac_pkg.sv -----
// ----------------------------------------------------------------------------
// cac_pkg
// Sizes, operation and status codes, and controller/datapath interface types
// for the capability access checker.
// ----------------------------------------------------------------------------
package cac_pkg;

  localparam int PROFILE_SLOTS = 64;
  localparam int PROC_SLOTS    = 4096;

  localparam int PROF_IDX_W = (PROFILE_SLOTS > 1) ? $clog2(PROFILE_SLOTS) : 1;
  localparam int PROC_IDX_W = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_BIND   = 2'd1,
    OP_CHECK  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_PROC = 3'd1,
    ST_NO_PROF  = 3'd2,
    ST_FULL     = 3'd3,
    ST_UNBOUND  = 3'd4,
    ST_MISSING  = 3'd5
  } status_e;

  // Controller -> datapath commands.
  typedef struct packed {
    logic accept;     // capture transaction, launch binding read
    logic clr_en;     // clearing pass: zero one binding entry
    logic eval_bind;  // binding data ready: finish create/bind/none, launch mask read
    logic eval_mask;  // mask data ready: finish check
  } ctrl_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic is_check;
    logic clr_last;
  } dp_stat_t;

endpackage

// ----- hdl/cac_ctrl.sv -----
// ----------------------------------------------------------------------------
// cac_ctrl
// Sequencer: clearing pass after reset, then one transaction at a time
// through binding lookup and (for check) mask lookup.
// ----------------------------------------------------------------------------
module cac_ctrl
  import cac_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o,
  output logic      busy_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_BIND,
    S_MASK
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (stat_i.clr_last) state_d = S_IDLE;
      S_IDLE:  if (start_i) state_d = S_BIND;
      S_BIND:  state_d = stat_i.is_check ? S_MASK : S_IDLE;
      S_MASK:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o.accept    = (state_q == S_IDLE) && start_i;
    cmd_o.clr_en    = (state_q == S_CLEAR);
    cmd_o.eval_bind = (state_q == S_BIND);
    cmd_o.eval_mask = (state_q == S_MASK);
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- hdl/cac_datapath.sv -----
// ----------------------------------------------------------------------------
// cac_datapath
// Profile mask memory, process binding memory, profile counter, request
// registers and result registers.
// ----------------------------------------------------------------------------
module cac_datapath
  import cac_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  output dp_stat_t  stat_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] proc_num_i,
  input  logic [6:0]  prof_num_i,
  input  logic [63:0] cap_bits_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic        granted_o,
  output logic [6:0]  new_prof_o
);

  localparam logic [16:0] PROC_LIMIT = 17'(PROC_SLOTS);
  localparam logic [6:0]  PROF_LIMIT = 7'(PROFILE_SLOTS);
  localparam logic [PROC_IDX_W-1:0] CLR_LAST = PROC_IDX_W'(PROC_SLOTS - 1);

  logic [63:0] mask_mem [PROFILE_SLOTS];
  logic [6:0]  bind_mem [PROC_SLOTS];

  // Request registers
  op_e         op_q;
  logic [15:0] proc_q;
  logic [6:0]  prof_q;
  logic [63:0] cap_q;

  logic [6:0]  bind_rd_q;
  logic [63:0] mask_rd_q;

  logic [6:0]  total_q, total_d;
  logic [PROC_IDX_W-1:0] clr_addr_q;

  logic        done_q, done_d;
  status_e     status_q, status_d;
  logic        granted_q, granted_d;
  logic [6:0]  new_prof_q, new_prof_d;

  logic        mask_we, bind_we, bind_mem_we;
  logic        proc_ok, unbound;
  logic [6:0]  bind_m1;
  logic [PROF_IDX_W-1:0] mask_raddr;
  logic [PROC_IDX_W-1:0] bind_waddr;
  logic [6:0]  bind_wdata;

  assign proc_ok    = ({1'b0, proc_q} < PROC_LIMIT);
  assign unbound    = (bind_rd_q == 7'd0) || (bind_rd_q > total_q) || (bind_rd_q > PROF_LIMIT);
  assign bind_m1    = bind_rd_q - 7'd1;
  assign mask_raddr = bind_m1[PROF_IDX_W-1:0];

  always_comb begin
    total_d    = total_q;
    done_d     = 1'b0;
    status_d   = status_q;
    granted_d  = granted_q;
    new_prof_d = new_prof_q;
    mask_we    = 1'b0;
    bind_we    = 1'b0;

    if (cmd_i.eval_bind) begin
      case (op_q)
        OP_CREATE: begin
          done_d    = 1'b1;
          granted_d = 1'b0;
          if (total_q >= PROF_LIMIT) begin
            status_d   = ST_FULL;
            new_prof_d = 7'd0;
          end else begin
            mask_we    = 1'b1;
            total_d    = total_q + 7'd1;
            status_d   = ST_OK;
            new_prof_d = total_q + 7'd1;
          end
        end
        OP_BIND: begin
          done_d     = 1'b1;
          granted_d  = 1'b0;
          new_prof_d = 7'd0;
          if (!proc_ok) begin
            status_d = ST_BAD_PROC;
          end else if ((prof_q == 7'd0) || (prof_q > total_q)) begin
            status_d = ST_NO_PROF;
          end else begin
            bind_we  = 1'b1;
            status_d = ST_OK;
          end
        end
        OP_NONE: begin
          done_d     = 1'b1;
          status_d   = ST_OK;
          granted_d  = 1'b0;
          new_prof_d = 7'd0;
        end
        default: ;  // check finishes after the mask read
      endcase
    end

    if (cmd_i.eval_mask) begin
      done_d     = 1'b1;
      new_prof_d = 7'd0;
      granted_d  = 1'b0;
      if (!proc_ok) begin
        status_d = ST_BAD_PROC;
      end else if (unbound) begin
        status_d = ST_UNBOUND;
      end else if ((mask_rd_q & cap_q) == cap_q) begin
        status_d  = ST_OK;
        granted_d = 1'b1;
      end else begin
        status_d = ST_MISSING;
      end
    end
  end

  // Binding memory: one write port shared by clearing pass and bind.
  assign bind_mem_we = cmd_i.clr_en | bind_we;
  assign bind_waddr  = cmd_i.clr_en ? clr_addr_q : proc_q[PROC_IDX_W-1:0];
  assign bind_wdata  = cmd_i.clr_en ? 7'd0 : prof_q;

  always_ff @(posedge clk_i) begin
    if (bind_mem_we) begin
      bind_mem[bind_waddr] <= bind_wdata;
    end
    if (cmd_i.accept) begin
      bind_rd_q <= bind_mem[proc_num_i[PROC_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mask_we) begin
      mask_mem[total_q[PROF_IDX_W-1:0]] <= cap_q;
    end
    if (cmd_i.eval_bind) begin
      mask_rd_q <= mask_mem[mask_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_e'(op_i);
      proc_q <= proc_num_i;
      prof_q <= prof_num_i;
      cap_q  <= cap_bits_i;
    end
    status_q   <= status_d;
    granted_q  <= granted_d;
    new_prof_q <= new_prof_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= 7'd0;
      clr_addr_q <= '0;
      done_q     <= 1'b0;
    end else begin
      total_q <= total_d;
      done_q  <= done_d;
      if (cmd_i.clr_en) begin
        clr_addr_q <= clr_addr_q + PROC_IDX_W'(1);
      end
    end
  end

  assign stat_o.is_check = (op_q == OP_CHECK);
  assign stat_o.clr_last = (clr_addr_q == CLR_LAST);

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign granted_o  = granted_q;
  assign new_prof_o = new_prof_q;

endmodule

// ----- hdl/capability_access_checker.sv -----
// ----------------------------------------------------------------------------
// capability_access_checker
// Capability profile table with per-process bindings: create, bind, check.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   start_i / busy_o   op_i, proc_num_i, prof_num_i, cap_bits_i
//  result    done_o (strobe)    status_o, granted_o, new_prof_o
//
//  Create, bind and unused op finish after the binding read; check also
//  waits for the dependent mask read.
//  After reset a clearing pass zeroes all PROC_SLOTS (4096) binding entries
//  with busy_o high.
//  One transaction at a time; the next may start in the cycle its result shows.
//  Results are shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module capability_access_checker
  import cac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] proc_num_i,
  input  logic [6:0]  prof_num_i,
  input  logic [63:0] cap_bits_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic        granted_o,
  output logic [6:0]  new_prof_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  cac_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  cac_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .op_i      (op_i),
    .proc_num_i(proc_num_i),
    .prof_num_i(prof_num_i),
    .cap_bits_i(cap_bits_i),
    .done_o    (done_o),
    .status_o  (status_o),
    .granted_o (granted_o),
    .new_prof_o(new_prof_o)
  );

endmodule

// ----- hdl/cac_checker.sv -----
// ----------------------------------------------------------------------------
// cac_checker
// Port-level assertions for the capability access checker, bound to the top.
// ----------------------------------------------------------------------------
`include "capability_access_checker_macros.svh"

module cac_checker
  import cac_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic        granted_o,
  input logic [6:0]  new_prof_o
);

  `CAC_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o, "accepted transaction did not raise busy")
  `CAC_ASSERT_NXT(a_strobe_single, clk_i, rst_ni, done_o, !done_o, "result strobe held two cycles")
  `CAC_ASSERT_IMP(a_result_after_busy, clk_i, rst_ni, done_o, $past(busy_o), "result without a transaction in flight")
  `CAC_ASSERT_IMP(a_grant_ok, clk_i, rst_ni, done_o && granted_o, status_o == ST_OK && new_prof_o == 7'd0, "grant with bad status or profile id")
  `CAC_ASSERT_IMP(a_new_prof_ok, clk_i, rst_ni, done_o && new_prof_o != 7'd0, status_o == ST_OK && !granted_o, "profile id with bad status or grant")

endmodule

bind capability_access_checker cac_checker u_cac_checker (.*);

// ----- tb/sv/access_outcome_board_pkg.sv -----
// ----------------------------------------------------------------------------
// access_outcome_board_pkg
// Keeps a shadow copy of the profile and binding tables. For each accepted
// request it works out the expected status, grant and profile id. It then
// compares every result strobe against the oldest outcome still pending.
// ----------------------------------------------------------------------------
package access_outcome_board_pkg;
  import cac_pkg::*;

  typedef struct {
    status_e  status;
    bit       granted;
    bit [6:0] new_prof;
  } outcome_t;

  class access_outcome_board;
    bit [63:0]   masks [PROFILE_SLOTS];
    int unsigned profile_count;
    bit [6:0]    bindings [PROC_SLOTS];
    outcome_t    outcome_q [$];
    int unsigned errors;

    function new();
      profile_count = 0;
      errors        = 0;
      foreach (masks[i]) masks[i] = '0;
      foreach (bindings[i]) bindings[i] = '0;
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction

    // Shadow update and expected outcome for one accepted transaction.
    function void predict_outcome(op_e op, bit [15:0] proc, bit [6:0] prof,
                                  bit [63:0] bits);
      outcome_t o;
      bit [6:0] bound_prof;
      o.status   = ST_OK;
      o.granted  = 1'b0;
      o.new_prof = '0;
      case (op)
        OP_CREATE: begin
          if (profile_count >= PROFILE_SLOTS) begin
            o.status = ST_FULL;
          end else begin
            masks[profile_count] = bits;
            profile_count++;
            o.new_prof = 7'(profile_count);
          end
        end
        OP_BIND: begin
          if (proc >= PROC_SLOTS) begin
            o.status = ST_BAD_PROC;
          end else if (prof == 0 || prof > profile_count) begin
            o.status = ST_NO_PROF;
          end else begin
            bindings[proc] = prof;
          end
        end
        OP_CHECK: begin
          if (proc >= PROC_SLOTS) begin
            o.status = ST_BAD_PROC;
          end else begin
            bound_prof = bindings[proc];
            if (bound_prof == 0 || bound_prof > profile_count) begin
              o.status = ST_UNBOUND;
            end else if ((masks[bound_prof - 1] & bits) == bits) begin
              o.granted = 1'b1;
            end else begin
              o.status = ST_MISSING;
            end
          end
        end
        default: ;
      endcase
      outcome_q.push_back(o);
    endfunction

    task report(string what);
      $display("ERROR: %s", what);
      errors++;
    endtask

    task check_result(logic [2:0] status, logic granted, logic [6:0] new_prof);
      outcome_t want;
      if (outcome_q.size() == 0) begin
        report("result strobe with no transaction pending");
      end else begin
        want = outcome_q.pop_front();
        if (status !== want.status)
          report($sformatf("status field got %0d want %0d", status, want.status));
        if (granted !== want.granted)
          report($sformatf("granted field got %0b want %0b", granted, want.granted));
        if (new_prof !== want.new_prof)
          report($sformatf("new_prof field got %0d want %0d", new_prof, want.new_prof));
      end
    endtask
  endclass

endpackage

// ----- tb/sv/capability_access_checker_test.sv -----
// ----------------------------------------------------------------------------
// capability_access_checker_test
// Self-checking bench for the capability access checker. It starts with
// directed create, bind and check transactions over the edge cases. Random
// traffic follows in three phases of sender gaps. The table fills up along
// the way.
// ----------------------------------------------------------------------------
module capability_access_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cac_pkg::*;
  import access_outcome_board_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          PHASE_ITEMS  = 350;
  localparam bit [63:0]   ALL_ONES     = '1;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  op_i;
  logic [15:0] proc_num_i;
  logic [6:0]  prof_num_i;
  logic [63:0] cap_bits_i;
  logic        done_o;
  logic [2:0]  status_o;
  logic        granted_o;
  logic [6:0]  new_prof_o;

  access_outcome_board board = new();
  int unsigned         cycles = 0;
  bit [15:0]           proc_pool [8];

  capability_access_checker u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .op_i       (op_i),
    .proc_num_i (proc_num_i),
    .prof_num_i (prof_num_i),
    .cap_bits_i (cap_bits_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .granted_o  (granted_o),
    .new_prof_o (new_prof_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_result(status_o, granted_o, new_prof_o);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(op_e op, bit [15:0] proc, bit [6:0] prof, bit [63:0] bits);
    start_i    <= 1'b1;
    op_i       <= op;
    proc_num_i <= proc;
    prof_num_i <= prof;
    cap_bits_i <= bits;
    do @(posedge clk_i); while (busy_o);
    board.predict_outcome(op, proc, prof, bits);
    @(negedge clk_i);
  endtask

  task automatic sender_gap(int unsigned pct);
    if ($urandom_range(99) < pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic bit [15:0] pick_proc();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return proc_pool[$urandom_range(7)];
    if (sel < 85) return 16'($urandom_range(PROC_SLOTS - 1));
    if (sel < 90) return 16'hffff;
    return 16'($urandom_range(65535, PROC_SLOTS));
  endfunction

  function automatic bit [6:0] pick_prof();
    int unsigned sel;
    int unsigned hi;
    sel = $urandom_range(99);
    hi  = (board.profile_count == 0) ? 1 : board.profile_count;
    if (sel < 80) return 7'($urandom_range(hi, 1));
    if (sel < 90) return '0;
    return 7'($urandom_range(127));
  endfunction

  // Requested bits drawn mostly around the mask bound to the process.
  function automatic bit [63:0] pick_request(bit [15:0] proc);
    bit [63:0]   held;
    bit [6:0]    bound_prof;
    int unsigned sel;
    held = rand64();
    if (proc < PROC_SLOTS) begin
      bound_prof = board.bindings[proc];
      if (bound_prof != 0 && bound_prof <= board.profile_count)
        held = board.masks[bound_prof - 1];
    end
    sel = $urandom_range(99);
    if (sel < 40) return held & rand64();
    if (sel < 50) return '0;
    if (sel < 75) return (held & rand64()) | (64'd1 << $urandom_range(63));
    return rand64();
  endfunction

  task automatic random_item();
    int unsigned sel;
    bit [15:0]   proc;
    bit [63:0]   mask;
    sel  = $urandom_range(99);
    proc = pick_proc();
    if (sel < 10) begin
      mask = rand64();
      if ($urandom_range(9) == 0) mask = ALL_ONES;
      else if ($urandom_range(19) == 0) mask = '0;
      send(OP_CREATE, proc, 7'($urandom_range(127)), mask);
    end else if (sel < 40) begin
      send(OP_BIND, proc, pick_prof(), rand64());
    end else if (sel < 95) begin
      send(OP_CHECK, proc, 7'($urandom_range(127)), pick_request(proc));
    end else begin
      send(OP_NONE, proc, 7'($urandom_range(127)), rand64());
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    op_i       = OP_CREATE;
    proc_num_i = '0;
    prof_num_i = '0;
    cap_bits_i = '0;
    proc_pool[0] = 16'd0;
    proc_pool[1] = 16'(PROC_SLOTS - 1);
    for (int i = 2; i < 8; i++) proc_pool[i] = 16'($urandom_range(PROC_SLOTS - 1));
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty tables, edge ids, out-of-range processes, empty request
    send(OP_CHECK,  16'd0,    7'd0,   ALL_ONES);
    send(OP_BIND,   16'd0,    7'd1,   '0);
    send(OP_CREATE, 16'd0,    7'd0,   ALL_ONES);
    send(OP_CREATE, 16'hffff, 7'h7f,  '0);
    send(OP_CREATE, 16'd5,    7'd3,   64'h5a5a_0f0f_a5a5_f0f0);
    send(OP_BIND,   16'd0,    7'd0,   '0);
    send(OP_BIND,   16'd0,    7'd4,   '0);
    send(OP_BIND,   16'd0,    7'd1,   '0);
    send(OP_BIND,   16'(PROC_SLOTS - 1), 7'd2, ALL_ONES);
    send(OP_BIND,   16'(PROC_SLOTS),     7'd1, '0);
    send(OP_BIND,   16'hffff, 7'h7f,  ALL_ONES);
    send(OP_CHECK,  16'd0,    7'd0,   ALL_ONES);
    send(OP_CHECK,  16'(PROC_SLOTS - 1), 7'd0, '0);
    send(OP_CHECK,  16'(PROC_SLOTS - 1), 7'd0, 64'd1);
    send(OP_CHECK,  16'hffff, 7'h7f,  '0);
    send(OP_CHECK,  16'(PROC_SLOTS),     7'd0, '0);
    send(OP_CHECK,  16'd1,    7'd0,   '0);
    send(OP_NONE,   16'hffff, 7'h7f,  ALL_ONES);
    send(OP_BIND,   16'd0,    7'h7f,  '0);
    send(OP_BIND,   16'd5,    7'd3,   '0);
    send(OP_CHECK,  16'd5,    7'd0,   64'h5a5a_0000_0000_0000);
    send(OP_CHECK,  16'd5,    7'd0,   64'h8000_0000_0000_0000);
    drain();

    for (int i = 0; i < PHASE_ITEMS; i++) begin
      sender_gap(15);
      random_item();
    end
    drain();
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      sender_gap(64);
      random_item();
    end
    drain();
    for (int i = 0; i < PHASE_ITEMS; i++) random_item();

    drain();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
